// ----- hdl/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/kacc_pkg.sv -----
// ---------------------------------------------------------------------------
// kacc_pkg
// Shared types and codes for the keyed accumulator.
// ---------------------------------------------------------------------------
package kacc_pkg;

  localparam int SumBits = 32;

  typedef enum logic [1:0] {
    KIND_ACC  = 2'd0,
    KIND_DUMP = 2'd1,
    KIND_BIG  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOMAX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LOAD,
    S_SORT,
    S_DUMP,
    S_BIG,
    S_OUT
  } state_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic acc;    // add amount to matching cell, or insert at the free slot
    logic load;   // copy stored entry into the sort register
    logic sort;   // one odd/even compare-exchange step
    logic phase;  // 0 even pairs, 1 odd pairs
    logic shift;  // move sort register towards cell 0
  } cell_ctl_t;

  function automatic logic [SumBits-1:0] sat_add(input logic [SumBits-1:0] a,
                                                 input logic [SumBits-1:0] b);
    logic [SumBits:0] s;
    s = {a[SumBits-1], a} + {b[SumBits-1], b};
    if (s[SumBits] != s[SumBits-1])
      sat_add = s[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    else
      sat_add = s[SumBits-1:0];
  endfunction

  // Ordering: larger sum first, then smaller key
  function automatic logic goes_first(input logic [31:0] ki, input logic [SumBits-1:0] si,
                                      input logic [31:0] kj, input logic [SumBits-1:0] sj);
    if (si != sj) goes_first = $signed(si) > $signed(sj);
    else goes_first = ki < kj;
  endfunction

endpackage

// ----- hdl/kacc_cell.sv -----
// ---------------------------------------------------------------------------
// kacc_cell
// One table slot: stored entry, plus a sort register that swaps with its
// neighbour in an odd/even transposition sort and shifts out towards slot 0.
// ---------------------------------------------------------------------------
module kacc_cell #(
  parameter int KEY_BITS = 24,
  parameter int IDX      = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kacc_pkg::cell_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic [31:0]            in_amount,
  input  logic                   insert_here,
  input  logic                   lo_valid,
  input  logic [KEY_BITS-1:0]    lo_key,
  input  logic [31:0]            lo_sum,
  input  logic                   hi_valid,
  input  logic [KEY_BITS-1:0]    hi_key,
  input  logic [31:0]            hi_sum,
  output logic                   valid,
  output logic                   hit,
  output logic [KEY_BITS-1:0]    key,
  output logic [31:0]            sum,
  output logic                   sv,
  output logic [KEY_BITS-1:0]    sk,
  output logic [31:0]            ss
);
  import kacc_pkg::*;

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r, sk_r, sk_nxt;
  logic [31:0]         sum_r, ss_r, ss_nxt;
  logic                sv_r, sv_nxt;
  logic                lead, swap_lo, swap_hi;

  assign hit   = valid_r && (key_r == in_key);
  assign valid = valid_r;
  assign key   = key_r;
  assign sum   = sum_r;
  assign sv    = sv_r;
  assign sk    = sk_r;
  assign ss    = ss_r;

  // Lower cell of its pair when parity matches the phase
  assign lead = ((IDX % 2) == 1) == ctl.phase;

  always_comb begin
    swap_hi = 1'b0;
    swap_lo = 1'b0;
    if (lead && hi_valid && sv_r)
      swap_hi = goes_first(32'(hi_key), hi_sum, 32'(sk_r), ss_r);
    if (!lead && lo_valid && sv_r)
      swap_lo = goes_first(32'(sk_r), ss_r, 32'(lo_key), lo_sum);
  end

  always_comb begin
    sv_nxt = sv_r;
    sk_nxt = sk_r;
    ss_nxt = ss_r;
    priority if (ctl.load) begin
      sv_nxt = valid_r;
      sk_nxt = key_r;
      ss_nxt = sum_r;
    end else if (ctl.shift) begin
      sv_nxt = hi_valid;
      sk_nxt = hi_key;
      ss_nxt = hi_sum;
    end else if (ctl.sort && swap_hi) begin
      sk_nxt = hi_key;
      ss_nxt = hi_sum;
    end else if (ctl.sort && swap_lo) begin
      sk_nxt = lo_key;
      ss_nxt = lo_sum;
    end else begin
      // hold the sort register
      sv_nxt = sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      sv_r <= sv_nxt;
      if (ctl.acc && insert_here) valid_r <= 1'b1;
    end
    sk_r <= sk_nxt;
    ss_r <= ss_nxt;
    if (ctl.acc && hit) begin
      sum_r <= sat_add(sum_r, in_amount);
    end else if (ctl.acc && insert_here) begin
      key_r <= in_key;
      sum_r <= in_amount;
    end
  end

endmodule

// ----- hdl/keyed_accumulator_sorted_dump_top.sv -----
// ---------------------------------------------------------------------------
// keyed_accumulator_sorted_dump_top
// Key/sum table built as a row of cells with a sorted dump and a maximum scan.
// ---------------------------------------------------------------------------
// channel  | direction | payload
// in_      | slave     | tdata {amount, entry_key}, tuser kind
// out_     | master    | tdata {out_sum, out_key}, tuser status, tlast last
// Accumulate: match in all cells at once, then result register; a further
//   word is accepted only after the result word has been taken.
// Dump: load, TABLE_ENTRIES odd/even sort steps, then one word per cycle
//   shifted out of cell 0 while out_tready is high. Biggest: scan of the cells.
// Reset clears valid bits and the sequencer; a held result word stalls the
// input, and out_tready low holds the dump and output states.
// ---------------------------------------------------------------------------
module keyed_accumulator_sorted_dump_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // entry_key[23:0], amount[55:24]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_key[24:0], out_sum[56:25], zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);
  import kacc_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;
  cell_ctl_t ctl;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] amt_r;
  logic [CW-1:0] cnt_r, cnt_nxt, step_r, step_nxt;
  logic [IW-1:0] scan_idx;
  logic phase_r;

  logic [TABLE_ENTRIES-1:0] c_valid, c_hit, c_sv, ins;
  logic [KEY_BITS-1:0] c_key [TABLE_ENTRIES];
  logic [31:0] c_sum [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] c_sk [TABLE_ENTRIES];
  logic [31:0] c_ss [TABLE_ENTRIES];

  logic [KEY_BITS-1:0] bk_r;
  logic [31:0] bs_r;
  logic found_r;

  logic ov_r, ol_r;
  logic [24:0] ok_r;
  logic [31:0] os_r;
  status_t ost_r;

  logic [24:0] hitkey;
  logic [31:0] hitsum;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      logic lo_v, hi_v;
      logic [KEY_BITS-1:0] lo_k, hi_k;
      logic [31:0] lo_s, hi_s;
      if (g == 0) begin : g_lo0
        assign lo_v = 1'b0; assign lo_k = '0; assign lo_s = '0;
      end else begin : g_lo
        assign lo_v = c_sv[g-1]; assign lo_k = c_sk[g-1]; assign lo_s = c_ss[g-1];
      end
      if (g == TABLE_ENTRIES-1) begin : g_hi0
        assign hi_v = 1'b0; assign hi_k = '0; assign hi_s = '0;
      end else begin : g_hi
        assign hi_v = c_sv[g+1]; assign hi_k = c_sk[g+1]; assign hi_s = c_ss[g+1];
      end
      assign ins[g] = (cnt_r == CW'(g)) && (c_hit == '0);
      kacc_cell #(.KEY_BITS(KEY_BITS), .IDX(g)) u_cell (
        .clk, .rst_n, .ctl, .in_key(key_r), .in_amount(amt_r),
        .insert_here(ins[g]),
        .lo_valid(lo_v), .lo_key(lo_k), .lo_sum(lo_s),
        .hi_valid(hi_v), .hi_key(hi_k), .hi_sum(hi_s),
        .valid(c_valid[g]), .hit(c_hit[g]), .key(c_key[g]), .sum(c_sum[g]),
        .sv(c_sv[g]), .sk(c_sk[g]), .ss(c_ss[g])
      );
    end
  endgenerate

  // Matching cell's stored sum, one-hot select
  always_comb begin
    hitsum = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (c_hit[i]) hitsum = c_sum[i];
  end
  assign hitkey = {1'b0, (KEY_BITS >= 24) ? 24'(key_r) : 24'(key_r)};

  assign scan_idx  = step_r[IW-1:0];
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {7'b0, os_r, ok_r};
  assign out_tuser  = ost_r;
  assign out_tlast  = ol_r;

  logic take_out;
  assign take_out = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ctl       = '0;
    ctl.phase = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          unique case (kind_t'(in_tuser))
            KIND_ACC:  state_nxt = S_ACC;
            KIND_DUMP: state_nxt = S_LOAD;
            KIND_BIG:  state_nxt = S_BIG;
            default:   state_nxt = S_IDLE;
          endcase
          step_nxt = '0;
        end
      end
      S_ACC: begin
        ctl.acc = 1'b1;
        if (c_hit == '0 && cnt_r != CW'(TABLE_ENTRIES)) cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_LOAD: begin
        ctl.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = (cnt_r == '0) ? S_OUT : S_SORT;
      end
      S_SORT: begin
        ctl.sort = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == CW'(TABLE_ENTRIES - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (take_out) begin
          ctl.shift = 1'b1;
          step_nxt  = step_r + 1'b1;
          if (step_r + 1'b1 == cnt_r) state_nxt = S_IDLE;
        end
      end
      S_BIG: begin
        step_nxt = step_r + 1'b1;
        if (step_r == CW'(TABLE_ENTRIES - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (take_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
      phase_r <= 1'b0;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      phase_r <= (state_r == S_SORT) ? !phase_r : 1'b0;
      if (state_r == S_IDLE) found_r <= 1'b0;
      if (state_r == S_BIG && c_valid[scan_idx] && $signed(c_sum[scan_idx]) > 0 &&
          (!found_r || goes_first(32'(c_key[scan_idx]), c_sum[scan_idx],
                                  32'(bk_r), bs_r)))
        found_r <= 1'b1;
      if ((state_r == S_DUMP || state_r == S_OUT) && take_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (state_r == S_IDLE && in_tvalid && in_tready) begin
      key_r <= KEY_BITS'(in_tdata[23:0]);
      amt_r <= in_tdata[55:24];
    end
    if (state_r == S_BIG && c_valid[scan_idx] && $signed(c_sum[scan_idx]) > 0 &&
        (!found_r || goes_first(32'(c_key[scan_idx]), c_sum[scan_idx], 32'(bk_r), bs_r))) begin
      bk_r <= c_key[scan_idx];
      bs_r <= c_sum[scan_idx];
    end
    if (state_r == S_ACC) begin
      ok_r <= hitkey;
      ol_r <= 1'b1;
      if (c_hit != '0) begin
        os_r <= sat_add(hitsum, amt_r);
        ost_r <= ST_OK;
      end else if (cnt_r == CW'(TABLE_ENTRIES)) begin
        os_r <= '0;
        ost_r <= ST_FULL;
      end else begin
        os_r <= amt_r;
        ost_r <= ST_OK;
      end
    end
    if (state_r == S_LOAD && cnt_r == '0) begin
      ok_r <= '0; os_r <= '0; ost_r <= ST_EMPTY; ol_r <= 1'b1;
    end
    if (state_r == S_BIG && step_r == CW'(TABLE_ENTRIES - 1)) begin
      ol_r <= 1'b1;
      if (found_r || (c_valid[scan_idx] && $signed(c_sum[scan_idx]) > 0)) begin
        ost_r <= ST_OK;
      end else begin
        ok_r <= '1; os_r <= '0; ost_r <= ST_NOMAX;
      end
    end
    if (state_r == S_OUT && take_out && ost_r == ST_OK && ol_r && step_r != '0) begin
      ok_r <= 25'(bk_r);
      os_r <= bs_r;
    end
    if (state_r == S_DUMP && take_out) begin
      ok_r  <= 25'(c_sk[0]);
      os_r  <= c_ss[0];
      ost_r <= ST_OK;
      ol_r  <= (step_r + 1'b1 == cnt_r);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CW'(TABLE_ENTRIES))
  `ASSERT_IMPL(a_busy_noaccept, state_r != S_IDLE, !in_tready)
  `ASSERT_NEXT(a_acc_out, state_r == S_ACC, state_r == S_OUT)
  `ASSERT_IMPL(a_hit_onehot, state_r == S_ACC, $onehot0(c_hit))

endmodule
